// ===== rtl/ptl_pkg.sv =====
// Shared types and constants for the priority task list.
// Command and result items, store write enables, field widths.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package ptl_pkg;

  localparam int TASK_SLOTS_DEF = 16;
  localparam int MAX_RESULTS    = 16;
  localparam int SLOT_W         = 4;
  localparam int PRIO_W         = 8;
  localparam int HANDLER_W      = 16;
  localparam int COUNT_W        = 5;

  typedef enum logic [1:0] {
    CMD_CREATE  = 2'd0,
    CMD_DESTROY = 2'd1,
    CMD_RUN     = 2'd2,
    CMD_FIND    = 2'd3
  } cmd_code_t;

  typedef struct packed {
    cmd_code_t              cmd;
    logic [PRIO_W-1:0]      priority_req;
    logic [HANDLER_W-1:0]   handler_id;
    logic [SLOT_W-1:0]      slot_id;
  } task_req_t;

  typedef struct packed {
    logic [SLOT_W-1:0]  result_slot;
    logic               ok;
    logic [COUNT_W-1:0] active_count;
    logic               last;
  } task_rsp_t;

  typedef struct packed {
    logic [PRIO_W-1:0]    prio;
    logic [HANDLER_W-1:0] handler;
  } data_entry_t;

  // Write enables into the slot store
  typedef struct packed {
    logic data_we;
    logic prev_we;
    logic next_we;
  } store_we_t;

endpackage

`default_nettype wire

// ===== rtl/ptl_store.sv =====
// Slot store: priority/handler memory and prev/next link memory.
// One read address shared by both, registered read data. Uses ptl_pkg.
`timescale 1ns / 1ps
`default_nettype none

module ptl_store #(
  parameter int TASK_SLOTS = ptl_pkg::TASK_SLOTS_DEF
) (
  input  logic                               clk,
  input  ptl_pkg::store_we_t                 we,
  input  logic [$clog2(TASK_SLOTS)-1:0]      data_waddr,
  input  logic [ptl_pkg::PRIO_W-1:0]         wprio,
  input  logic [ptl_pkg::HANDLER_W-1:0]      whandler,
  input  logic [$clog2(TASK_SLOTS)-1:0]      link_waddr,
  input  logic [$clog2(TASK_SLOTS+1)-1:0]    wprev,
  input  logic [$clog2(TASK_SLOTS+1)-1:0]    wnext,
  input  logic [$clog2(TASK_SLOTS)-1:0]      rd_addr,
  output logic [ptl_pkg::PRIO_W-1:0]         rd_prio,
  output logic [ptl_pkg::HANDLER_W-1:0]      rd_handler,
  output logic [$clog2(TASK_SLOTS+1)-1:0]    rd_prev,
  output logic [$clog2(TASK_SLOTS+1)-1:0]    rd_next
);

  localparam int LW = $clog2(TASK_SLOTS + 1);

  ptl_pkg::data_entry_t data_mem [TASK_SLOTS];
  logic [2*LW-1:0]      link_mem [TASK_SLOTS];

  ptl_pkg::data_entry_t data_q;
  logic [2*LW-1:0]      link_q;

  always_ff @(posedge clk) begin
    if (we.data_we) begin
      data_mem[data_waddr] <= '{prio: wprio, handler: whandler};
    end
    data_q <= data_mem[rd_addr];
  end

  // Prev in the upper half, next in the lower half; each half writes alone
  always_ff @(posedge clk) begin
    if (we.prev_we) begin
      link_mem[link_waddr][2*LW-1:LW] <= wprev;
    end
    if (we.next_we) begin
      link_mem[link_waddr][LW-1:0] <= wnext;
    end
    link_q <= link_mem[rd_addr];
  end

  assign rd_prio    = data_q.prio;
  assign rd_handler = data_q.handler;
  assign rd_prev    = link_q[2*LW-1:LW];
  assign rd_next    = link_q[LW-1:0];

endmodule

`default_nettype wire

// ===== rtl/priority_task_list.sv =====
// Priority task list top level: command sequencer, slot marks, head and count.
// Depends on ptl_pkg and ptl_store.
//
//  channel   | ports                      | handshake
//  ----------+----------------------------+-------------------------------------
//  command   | start, busy, task_req      | taken on start && !busy
//  result    | strobe, task_rsp           | one strobe per result, no back-pressure
//
// Steps: create on a full table or an empty list answers straight from idle, else
// it walks the list from the head to the insert point and then fixes the links.
// Destroy answers straight from idle when ignored, else it reads the slot and
// fixes the links. Run gives one result per cycle after a read of the head. Find
// scans the slots from index 0 up to the first match or the last slot. The store
// has a single read port, so each walked node or scanned slot costs one read.
// Reset: synchronous; clears slot marks, count, head and the sequencer. The
// memories are not cleared; only entries of active slots are ever used.
// Results cannot be stalled; busy stays high until the last result is issued.
`timescale 1ns / 1ps
`default_nettype none

module priority_task_list #(
  parameter int TASK_SLOTS = ptl_pkg::TASK_SLOTS_DEF
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  output logic               busy,
  input  ptl_pkg::task_req_t task_req,
  output logic               strobe,
  output ptl_pkg::task_rsp_t task_rsp
);

  localparam int SW = $clog2(TASK_SLOTS);
  localparam int LW = $clog2(TASK_SLOTS + 1);
  localparam int CW = $clog2(TASK_SLOTS + 1);
  localparam int KW = $clog2(ptl_pkg::MAX_RESULTS);

  localparam logic [LW-1:0] NO_LINK   = LW'(TASK_SLOTS);
  localparam logic [SW-1:0] LAST_SLOT = SW'(TASK_SLOTS - 1);
  localparam logic [KW-1:0] LAST_K    = KW'(ptl_pkg::MAX_RESULTS - 1);

  typedef logic [ptl_pkg::SLOT_W-1:0]  rslot_t;
  typedef logic [ptl_pkg::COUNT_W-1:0] rcount_t;

  typedef enum logic [7:0] {
    S_IDLE    = 8'b0000_0001,
    S_CR_WALK = 8'b0000_0010,
    S_CR_FIX  = 8'b0000_0100,
    S_CR_FIX2 = 8'b0000_1000,
    S_DS_RD   = 8'b0001_0000,
    S_DS_FIX  = 8'b0010_0000,
    S_RUN     = 8'b0100_0000,
    S_FIND    = 8'b1000_0000
  } state_t;

  // Control registers
  state_t              state, state_next;
  logic [TASK_SLOTS-1:0] active_marks, active_marks_next;
  logic [CW-1:0]       count, count_next;
  logic [LW-1:0]       head, head_next;
  logic [KW-1:0]       k, k_next;

  // Working registers of the current item
  ptl_pkg::task_req_t  req, req_next;
  logic [SW-1:0]       cur, cur_next;   // walk or run node, destroy slot or find index
  logic [SW-1:0]       nw, nw_next;     // slot being created
  logic [LW-1:0]       p_link, p_link_next;
  logic [LW-1:0]       n_link, n_link_next;
  logic                ins_front, ins_front_next;

  // Result issue
  logic                emit;
  rslot_t              emit_slot;
  logic                emit_ok;
  logic                emit_last;

  // Store access
  ptl_pkg::store_we_t  we;
  logic [SW-1:0]       rd_addr, data_waddr, link_waddr;
  logic [LW-1:0]       wprev, wnext;
  logic [ptl_pkg::PRIO_W-1:0]    rd_prio;
  logic [ptl_pkg::HANDLER_W-1:0] rd_handler;
  logic [LW-1:0]       rd_prev, rd_next;

  // Lowest free slot
  logic [SW-1:0]       free_slot;
  logic                full;

  logic [SW-1:0]       sid_idx;
  logic                sid_in;
  logic                run_end;
  logic                match;

  ptl_store #(
    .TASK_SLOTS (TASK_SLOTS)
  ) u_store (
    .clk        (clk),
    .we         (we),
    .data_waddr (data_waddr),
    .wprio      (task_req.priority_req),
    .whandler   (task_req.handler_id),
    .link_waddr (link_waddr),
    .wprev      (wprev),
    .wnext      (wnext),
    .rd_addr    (rd_addr),
    .rd_prio    (rd_prio),
    .rd_handler (rd_handler),
    .rd_prev    (rd_prev),
    .rd_next    (rd_next)
  );

  always_comb begin
    free_slot = '0;
    for (int i = TASK_SLOTS - 1; i >= 0; i--) begin
      if (!active_marks[i]) begin
        free_slot = SW'(i);
      end
    end
  end

  assign full    = &active_marks;
  assign sid_idx = SW'(task_req.slot_id);
  assign sid_in  = (int'(task_req.slot_id) < TASK_SLOTS);
  assign run_end = (rd_next >= NO_LINK) || (k == LAST_K);
  assign match   = active_marks[cur] && (rd_handler == req.handler_id);
  assign busy    = (state != S_IDLE);

  always_comb begin
    state_next        = state;
    active_marks_next = active_marks;
    count_next        = count;
    head_next         = head;
    k_next            = k;
    req_next          = req;
    cur_next          = cur;
    nw_next           = nw;
    p_link_next       = p_link;
    n_link_next       = n_link;
    ins_front_next    = ins_front;

    emit      = 1'b0;
    emit_slot = '0;
    emit_ok   = 1'b0;
    emit_last = 1'b1;

    we         = '0;
    rd_addr    = cur;
    data_waddr = free_slot;
    link_waddr = nw;
    wprev      = NO_LINK;
    wnext      = NO_LINK;

    unique case (state)
      S_IDLE: begin
        if (start) begin
          req_next = task_req;
          unique case (task_req.cmd)
            ptl_pkg::CMD_CREATE: begin
              if (full) begin
                emit = 1'b1;
              end else begin
                // Store priority and handler now; links follow the walk
                nw_next    = free_slot;
                we.data_we = 1'b1;
                if (head == NO_LINK) begin
                  // Empty list: the new slot is head and tail alone
                  we.prev_we                    = 1'b1;
                  we.next_we                    = 1'b1;
                  link_waddr                    = free_slot;
                  head_next                     = LW'(free_slot);
                  active_marks_next[free_slot]  = 1'b1;
                  count_next                    = count + CW'(1);
                  emit                          = 1'b1;
                  emit_slot                     = rslot_t'(free_slot);
                  emit_ok                       = 1'b1;
                end else begin
                  rd_addr    = head[SW-1:0];
                  cur_next   = head[SW-1:0];
                  state_next = S_CR_WALK;
                end
              end
            end
            ptl_pkg::CMD_DESTROY: begin
              if (!sid_in || !active_marks[sid_idx]) begin
                emit      = 1'b1;
                emit_slot = rslot_t'(task_req.slot_id);
              end else begin
                rd_addr                    = sid_idx;
                cur_next                   = sid_idx;
                active_marks_next[sid_idx] = 1'b0;
                count_next                 = count - CW'(1);
                state_next                 = S_DS_RD;
              end
            end
            ptl_pkg::CMD_RUN: begin
              if (head == NO_LINK) begin
                emit = 1'b1;
              end else begin
                rd_addr    = head[SW-1:0];
                cur_next   = head[SW-1:0];
                k_next     = '0;
                state_next = S_RUN;
              end
            end
            ptl_pkg::CMD_FIND: begin
              rd_addr    = '0;
              cur_next   = '0;
              state_next = S_FIND;
            end
            default: begin
              state_next = S_IDLE;
            end
          endcase
        end
      end

      S_CR_WALK: begin
        // Insert in front of the first node with a strictly larger value
        if (req.priority_req < rd_prio) begin
          we.prev_we     = 1'b1;
          we.next_we     = 1'b1;
          wprev          = rd_prev;
          wnext          = LW'(cur);
          ins_front_next = 1'b1;
          p_link_next    = rd_prev;
          state_next     = S_CR_FIX;
        end else if (rd_next >= NO_LINK) begin
          // Append after the tail
          we.prev_we     = 1'b1;
          we.next_we     = 1'b1;
          wprev          = LW'(cur);
          wnext          = NO_LINK;
          ins_front_next = 1'b0;
          state_next     = S_CR_FIX;
        end else begin
          // Advance: read the next node right away
          cur_next = rd_next[SW-1:0];
          rd_addr  = rd_next[SW-1:0];
        end
      end

      S_CR_FIX: begin
        link_waddr = cur;
        if (ins_front) begin
          we.prev_we = 1'b1;
          wprev      = LW'(nw);
        end else begin
          we.next_we = 1'b1;
          wnext      = LW'(nw);
        end
        if (ins_front && (p_link < NO_LINK)) begin
          state_next = S_CR_FIX2;
        end else begin
          if (ins_front) begin
            head_next = LW'(nw);
          end
          active_marks_next[nw] = 1'b1;
          count_next            = count + CW'(1);
          emit                  = 1'b1;
          emit_slot             = rslot_t'(nw);
          emit_ok               = 1'b1;
          state_next            = S_IDLE;
        end
      end

      S_CR_FIX2: begin
        // Point the predecessor at the new slot
        link_waddr            = p_link[SW-1:0];
        we.next_we            = 1'b1;
        wnext                 = LW'(nw);
        active_marks_next[nw] = 1'b1;
        count_next            = count + CW'(1);
        emit                  = 1'b1;
        emit_slot             = rslot_t'(nw);
        emit_ok               = 1'b1;
        state_next            = S_IDLE;
      end

      S_DS_RD: begin
        p_link_next = rd_prev;
        n_link_next = rd_next;
        if (rd_prev < NO_LINK) begin
          link_waddr = rd_prev[SW-1:0];
          we.next_we = 1'b1;
          wnext      = rd_next;
        end else begin
          head_next = rd_next;
        end
        if (rd_next < NO_LINK) begin
          state_next = S_DS_FIX;
        end else begin
          emit       = 1'b1;
          emit_slot  = rslot_t'(cur);
          emit_ok    = 1'b1;
          state_next = S_IDLE;
        end
      end

      S_DS_FIX: begin
        link_waddr = n_link[SW-1:0];
        we.prev_we = 1'b1;
        wprev      = p_link;
        emit       = 1'b1;
        emit_slot  = rslot_t'(cur);
        emit_ok    = 1'b1;
        state_next = S_IDLE;
      end

      S_RUN: begin
        emit      = 1'b1;
        emit_slot = rslot_t'(cur);
        emit_ok   = 1'b1;
        emit_last = run_end;
        if (run_end) begin
          state_next = S_IDLE;
        end else begin
          cur_next = rd_next[SW-1:0];
          rd_addr  = rd_next[SW-1:0];
          k_next   = k + KW'(1);
        end
      end

      S_FIND: begin
        if (match) begin
          emit       = 1'b1;
          emit_slot  = rslot_t'(cur);
          emit_ok    = 1'b1;
          state_next = S_IDLE;
        end else if (cur == LAST_SLOT) begin
          emit       = 1'b1;
          emit_slot  = '1;
          state_next = S_IDLE;
        end else begin
          cur_next = cur + SW'(1);
          rd_addr  = cur + SW'(1);
        end
      end

      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= S_IDLE;
      active_marks <= '0;
      count        <= '0;
      head         <= NO_LINK;
      strobe       <= 1'b0;
    end else begin
      state        <= state_next;
      active_marks <= active_marks_next;
      count        <= count_next;
      head         <= head_next;
      strobe       <= emit;
    end
  end

  // Payload registers: no reset
  always_ff @(posedge clk) begin
    req       <= req_next;
    cur       <= cur_next;
    nw        <= nw_next;
    p_link    <= p_link_next;
    n_link    <= n_link_next;
    ins_front <= ins_front_next;
    k         <= k_next;
    if (emit) begin
      task_rsp.result_slot  <= emit_slot;
      task_rsp.ok           <= emit_ok;
      task_rsp.active_count <= rcount_t'(count_next);
      task_rsp.last         <= emit_last;
    end
  end

endmodule

`default_nettype wire

// ===== rtl/ptl_checker.sv =====
// Port-level checks for the priority task list, bound to the top level.
// Depends on ptl_pkg and priority_task_list.
`timescale 1ns / 1ps
`default_nettype none

module ptl_checker (
  input logic               clk,
  input logic               rst,
  input logic               busy,
  input logic               strobe,
  input ptl_pkg::task_rsp_t task_rsp
);

  // A run streams its entries without gaps
  a_run_no_gap: assert property (@(posedge clk) disable iff (rst)
    strobe && !task_rsp.last |=> strobe)
    else $error("result stream broke before last");

  // More results pending means the item is still in progress
  a_busy_mid: assert property (@(posedge clk) disable iff (rst)
    strobe && !task_rsp.last |-> busy)
    else $error("busy low while results remain");

  // A run changes no state, so the count holds across its entries
  a_count_hold: assert property (@(posedge clk) disable iff (rst)
    strobe && !task_rsp.last |=> $stable(task_rsp.active_count))
    else $error("active count moved during a run");

  // Leaving busy always coincides with the final result
  a_done_last: assert property (@(posedge clk) disable iff (rst)
    !$past(rst) && $fell(busy) |-> strobe && task_rsp.last)
    else $error("busy dropped without a final result");

endmodule

bind priority_task_list ptl_checker u_ptl_checker (
  .clk      (clk),
  .rst      (rst),
  .busy     (busy),
  .strobe   (strobe),
  .task_rsp (task_rsp)
);

`default_nettype wire
